// ===== sv/hpt_pkg.sv =====
// Shared types, constants and helpers for the homogeneous point transform.
// Used by every module of the core; depends on nothing.
package hpt_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int ENTRY_WIDTH = 16;
    localparam int ROW_WIDTH   = 3 * ENTRY_WIDTH;
    localparam int CFG_IDX_W   = 2;
    // products and sums carry 16 fraction bits
    localparam int SUM_WIDTH   = COORD_WIDTH + ENTRY_WIDTH + 2;
    // numerator is the sum scaled by 16
    localparam int NUM_WIDTH   = SUM_WIDTH + 4;
    // one quotient bit per divider cell
    localparam int QUO_WIDTH   = NUM_WIDTH;
    localparam int DEN_WIDTH   = SUM_WIDTH;

    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROW1 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROW2 = 2'd2;

    localparam logic [ROW_WIDTH-1:0] ROW0_RESET = 48'h0000_0000_1000;
    localparam logic [ROW_WIDTH-1:0] ROW1_RESET = 48'h0000_1000_0000;
    localparam logic [ROW_WIDTH-1:0] ROW2_RESET = 48'h1000_0000_0000;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] point_x;
        logic signed [COORD_WIDTH-1:0] point_y;
    } in_word_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_x;
        logic signed [COORD_WIDTH-1:0] out_y;
        logic                          zero_w;
        logic                          saturated;
    } out_word_t;

    // one word travelling down the divider chain
    typedef struct packed {
        logic                 vld;
        logic [NUM_WIDTH-1:0] rem_x;   // magnitude remainders
        logic [NUM_WIDTH-1:0] rem_y;
        logic [NUM_WIDTH-1:0] num_x;   // magnitude numerators, shifted out MSB first
        logic [NUM_WIDTH-1:0] num_y;
        logic [QUO_WIDTH-1:0] quo_x;
        logic [QUO_WIDTH-1:0] quo_y;
        logic [DEN_WIDTH-1:0] den;     // |w|
        logic                 neg_x;
        logic                 neg_y;
        logic                 zero_w;
    } div_word_t;

endpackage

// ===== sv/homogeneous_point_transform_core.sv =====
// Top level of the homogeneous 2D point transform: matrix registers,
// multiply front end, chain of divider cells, result register.
// Depends on hpt_pkg, hpt_mac, hpt_div_cell, hpt_out.
//
//  channel   signals                         dir
//  input     in_valid / in_stall / in_word    in
//  output    out_valid / out_stall / out_word out
//  config    cfg_we / cfg_index / cfg_data    in
//
// One word per cycle while out_stall does not hold the pipe; each word passes through the
// multiply front end, the chain of 38 one-bit divider cells and the result register.
// Reset loads the identity matrix and empties the pipe.
// out_stall freezes the whole pipe while a result waits; in_stall follows it.
module homogeneous_point_transform_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  hpt_pkg::in_word_t             in_word,
    output logic                          out_valid,
    input  logic                          out_stall,
    output hpt_pkg::out_word_t            out_word,
    input  logic                          cfg_we,
    input  logic [hpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [hpt_pkg::ROW_WIDTH-1:0] cfg_data
);
    import hpt_pkg::*;

    logic [ROW_WIDTH-1:0] row0_reg, row1_reg, row2_reg;
    logic                 adv;
    div_word_t            chain [QUO_WIDTH+1];

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row0_reg <= ROW0_RESET;
            row1_reg <= ROW1_RESET;
            row2_reg <= ROW2_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ROW0: row0_reg <= cfg_data;
                REG_ROW1: row1_reg <= cfg_data;
                REG_ROW2: row2_reg <= cfg_data;
                default:  ;
            endcase
        end
    end

    assign in_stall = !adv;

    hpt_mac u_mac
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (in_valid),
        .in_word  (in_word),
        .row0     (row0_reg),
        .row1     (row1_reg),
        .row2     (row2_reg),
        .div_word (chain[0])
    );

    // divider chain, one quotient bit per cell
    for (genvar i = 0; i < QUO_WIDTH; i++)
    begin : g_cell
        hpt_div_cell u_cell
        (
            .clk   (clk),
            .rst_n (rst_n),
            .adv   (adv),
            .d_in  (chain[i]),
            .d_out (chain[i+1])
        );
    end

    hpt_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .d_in      (chain[QUO_WIDTH]),
        .out_stall (out_stall),
        .adv       (adv),
        .out_valid (out_valid),
        .out_word  (out_word)
    );

endmodule

// ===== sv/hpt_mac.sv =====
// Matrix multiply front end: three dot products of (x, y, 1) with the matrix.
// Depends on hpt_pkg. Two register stages: products, then sums and magnitudes.
module hpt_mac
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_vld,
    input  hpt_pkg::in_word_t             in_word,
    input  logic [hpt_pkg::ROW_WIDTH-1:0] row0,
    input  logic [hpt_pkg::ROW_WIDTH-1:0] row1,
    input  logic [hpt_pkg::ROW_WIDTH-1:0] row2,
    output hpt_pkg::div_word_t            div_word
);
    import hpt_pkg::*;

    localparam int PW = COORD_WIDTH + ENTRY_WIDTH;

    logic                       p_vld_reg;
    logic signed [PW-1:0]       px_reg [3];
    logic signed [PW-1:0]       py_reg [3];
    logic signed [ENTRY_WIDTH-1:0] pc_reg [3];

    logic                       vld_reg;
    div_word_t                  word_reg;

    logic signed [SUM_WIDTH-1:0] sum_c [3];
    logic signed [NUM_WIDTH-1:0] num_c [2];
    logic [NUM_WIDTH-1:0]        mag_c [2];
    logic [DEN_WIDTH-1:0]        den_c;

    // stage 1: products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_vld_reg <= in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int j = 0; j < 3; j++)
            begin
                px_reg[j] <= PW'(in_word.point_x *
                    $signed(row0[j*ENTRY_WIDTH +: ENTRY_WIDTH]));
                py_reg[j] <= PW'(in_word.point_y *
                    $signed(row1[j*ENTRY_WIDTH +: ENTRY_WIDTH]));
                pc_reg[j] <= $signed(row2[j*ENTRY_WIDTH +: ENTRY_WIDTH]);
            end
        end
    end

    // sums, then sign and magnitude for the divider
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            sum_c[j] = SUM_WIDTH'(px_reg[j]) + SUM_WIDTH'(py_reg[j])
                     + (SUM_WIDTH'(pc_reg[j]) <<< 4);
        end
        for (int j = 0; j < 2; j++)
        begin
            num_c[j] = NUM_WIDTH'(sum_c[j]) <<< 4;
            mag_c[j] = num_c[j][NUM_WIDTH-1] ? NUM_WIDTH'(-num_c[j])
                                             : NUM_WIDTH'(num_c[j]);
        end
        den_c = sum_c[2][SUM_WIDTH-1] ? DEN_WIDTH'(-sum_c[2]) : DEN_WIDTH'(sum_c[2]);
    end

    // stage 2: sums
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg.vld    <= 1'b0;   // valid is carried by vld_reg
            word_reg.rem_x  <= '0;
            word_reg.rem_y  <= '0;
            word_reg.num_x  <= mag_c[0];
            word_reg.num_y  <= mag_c[1];
            word_reg.quo_x  <= '0;
            word_reg.quo_y  <= '0;
            word_reg.den    <= den_c;
            word_reg.neg_x  <= num_c[0][NUM_WIDTH-1] ^ sum_c[2][SUM_WIDTH-1];
            word_reg.neg_y  <= num_c[1][NUM_WIDTH-1] ^ sum_c[2][SUM_WIDTH-1];
            word_reg.zero_w <= (sum_c[2] == '0);
        end
    end

    always_comb
    begin
        div_word     = word_reg;
        div_word.vld = vld_reg;
    end

endmodule

// ===== sv/hpt_div_cell.sv =====
// One restoring-division cell: produces one quotient bit for x and for y.
// Depends on hpt_pkg. Registered; chained to form the divider.
module hpt_div_cell
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               adv,
    input  hpt_pkg::div_word_t d_in,
    output hpt_pkg::div_word_t d_out
);
    import hpt_pkg::*;

    div_word_t             word_reg;
    logic                  vld_reg;
    logic [NUM_WIDTH:0]    tx, ty;
    logic [NUM_WIDTH:0]    dx;
    div_word_t             word_next;

    // shift in next numerator bit, try subtracting the divisor
    always_comb
    begin
        word_next = d_in;
        tx = {d_in.rem_x, d_in.num_x[NUM_WIDTH-1]};
        ty = {d_in.rem_y, d_in.num_y[NUM_WIDTH-1]};
        dx = (NUM_WIDTH+1)'(d_in.den);
        word_next.num_x = d_in.num_x << 1;
        word_next.num_y = d_in.num_y << 1;
        if (tx >= dx)
        begin
            word_next.rem_x = NUM_WIDTH'(tx - dx);
            word_next.quo_x = {d_in.quo_x[QUO_WIDTH-2:0], 1'b1};
        end
        else
        begin
            word_next.rem_x = NUM_WIDTH'(tx);
            word_next.quo_x = {d_in.quo_x[QUO_WIDTH-2:0], 1'b0};
        end
        if (ty >= dx)
        begin
            word_next.rem_y = NUM_WIDTH'(ty - dx);
            word_next.quo_y = {d_in.quo_y[QUO_WIDTH-2:0], 1'b1};
        end
        else
        begin
            word_next.rem_y = NUM_WIDTH'(ty);
            word_next.quo_y = {d_in.quo_y[QUO_WIDTH-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg <= d_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    always_comb
    begin
        d_out     = word_reg;
        d_out.vld = vld_reg;
    end

endmodule

// ===== sv/hpt_out.sv =====
// Result stage: applies signs, saturates, handles zero w; one output register.
// Depends on hpt_pkg. Holds the word while the consumer stalls.
module hpt_out
(
    input  logic                clk,
    input  logic                rst_n,
    input  hpt_pkg::div_word_t  d_in,
    input  logic                out_stall,
    output logic                adv,
    output logic                out_valid,
    output hpt_pkg::out_word_t  out_word
);
    import hpt_pkg::*;

    localparam logic signed [QUO_WIDTH:0] CMAX = (QUO_WIDTH+1)'((1 << (COORD_WIDTH-1)) - 1);
    localparam logic signed [QUO_WIDTH:0] CMIN = -CMAX - 1;

    logic               valid_reg;
    out_word_t          word_reg;
    out_word_t          word_next;
    logic signed [QUO_WIDTH:0] qx, qy;
    logic               sx, sy;

    // the pipe moves whenever the output register is free or being taken
    assign adv = !valid_reg || !out_stall;

    always_comb
    begin
        qx = d_in.neg_x ? -$signed({1'b0, d_in.quo_x}) : $signed({1'b0, d_in.quo_x});
        qy = d_in.neg_y ? -$signed({1'b0, d_in.quo_y}) : $signed({1'b0, d_in.quo_y});
        sx = (qx > CMAX) || (qx < CMIN);
        sy = (qy > CMAX) || (qy < CMIN);
        word_next.out_x = (qx > CMAX) ? COORD_WIDTH'(CMAX) :
                          (qx < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(qx);
        word_next.out_y = (qy > CMAX) ? COORD_WIDTH'(CMAX) :
                          (qy < CMIN) ? COORD_WIDTH'(CMIN) : COORD_WIDTH'(qy);
        word_next.saturated = sx || sy;
        word_next.zero_w    = d_in.zero_w;
        if (d_in.zero_w)
        begin
            word_next.out_x     = '0;
            word_next.out_y     = '0;
            word_next.saturated = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= d_in.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

`ifndef SYNTHESIS
    a_zero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && word_reg.zero_w |-> word_reg.out_x == '0 && !word_reg.saturated)
        else $error("zero w word carries data");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_stall |=> valid_reg && $stable(word_reg))
        else $error("stalled result changed");
    a_adv: assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg |-> adv)
        else $error("pipe stopped with empty output");
`endif

endmodule
